@@ rtl/psu_pkg.sv @@
// Shared constants, types and helper functions of the PNG scanline unfilter block.
package psu_pkg;

	localparam int MAX_LINE_BYTES = 8192;
	localparam int POS_W  = $clog2(MAX_LINE_BYTES + 1);
	localparam int ADDR_W = $clog2(MAX_LINE_BYTES);
	localparam int BPP_W  = 4;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_FILT = 2'd1;
	localparam logic [1:0] STAT_OVERLONG = 2'd2;

	// One accepted item as it sits in the input register.
	typedef struct packed {
		logic              is_filter;
		logic [7:0]        data;
		logic              last;
		logic [2:0]        kind;
		logic              bad;
		logic              in_store;
		logic              use_b;
		logic [ADDR_W-1:0] addr;
	} psu_item_t;

	// History tap for the configured pixel distance; 0 acts as 1 and 9..15 as 8.
	function automatic logic [2:0] bpp_tap(input logic [BPP_W-1:0] bpp);
		logic [2:0] tap;
		if (bpp == '0) begin
			tap = 3'd0;
		end else if (bpp > BPP_W'(8)) begin
			tap = 3'd7;
		end else begin
			tap = 3'(bpp - BPP_W'(1));
		end
		return tap;
	endfunction

	// Paeth predictor on left (a), above (b) and upper-left (c).
	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		logic [7:0] res;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
		pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
		pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
		if (pa <= pb && pa <= pc) begin
			res = a;
		end else if (pb <= pc) begin
			res = b;
		end else begin
			res = c;
		end
		return res;
	endfunction

endpackage

@@ rtl/psu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/psu_ctrl.sv @@
// Input side: line framing state, line store read issue and the input register.
module psu_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                in_data,
	input  logic                      in_last,
	input  logic                      in_pass_start,
	input  logic                      advance,
	output logic                      item_valid_s1,
	output psu_pkg::psu_item_t        item_s1,
	output logic                      rd_en,
	output logic [psu_pkg::ADDR_W-1:0] rd_addr
);

	logic                      expect_q;
	logic                      prior_valid_q;
	logic [2:0]                kind_q;
	logic                      bad_q;
	logic [psu_pkg::POS_W-1:0] pos_q;
	logic                      accept;
	logic                      in_store;
	logic                      is_bad;

	assign in_ready = !item_valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign in_store = pos_q < psu_pkg::POS_W'(psu_pkg::MAX_LINE_BYTES);
	assign is_bad   = in_data > {5'b0, psu_pkg::FILT_PAETH};
	assign rd_en    = accept && !expect_q && in_store;
	assign rd_addr  = pos_q[psu_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q      <= 1'b1;
			prior_valid_q <= 1'b0;
			kind_q        <= psu_pkg::FILT_NONE;
			bad_q         <= 1'b0;
			pos_q         <= '0;
			item_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				item_valid_s1 <= 1'b1;
			end else if (advance) begin
				item_valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (expect_q) begin
					if (in_pass_start) begin
						prior_valid_q <= 1'b0;
					end
					bad_q    <= is_bad;
					kind_q   <= is_bad ? psu_pkg::FILT_NONE : in_data[2:0];
					pos_q    <= '0;
					expect_q <= in_last;
				end else if (in_last) begin
					expect_q      <= 1'b1;
					prior_valid_q <= 1'b1;
					pos_q         <= '0;
				end else if (in_store) begin
					pos_q <= pos_q + psu_pkg::POS_W'(1);
				end
			end
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.is_filter <= expect_q;
			item_s1.data      <= in_data;
			item_s1.last      <= in_last;
			item_s1.kind      <= kind_q;
			item_s1.bad       <= bad_q;
			item_s1.in_store  <= in_store;
			item_s1.use_b     <= in_store && prior_valid_q;
			item_s1.addr      <= pos_q[psu_pkg::ADDR_W-1:0];
		end
	end

endmodule

@@ rtl/psu_recon.sv @@
// Reconstruction datapath: neighbor histories, predictors and the result register.
module psu_recon (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [psu_pkg::BPP_W-1:0]  bpp,
	input  logic                       item_valid_s1,
	input  psu_pkg::psu_item_t         item_s1,
	input  logic [7:0]                 above_byte,
	output logic                       advance,
	output logic                       wr_en,
	output logic [psu_pkg::ADDR_W-1:0] wr_addr,
	output logic [7:0]                 wr_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 pixel_q,
	output logic                       last_q,
	output logic [1:0]                 status_q
);

	logic [7:0] left_q [8];
	logic [7:0] upleft_q [8];
	logic [2:0] tap;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] sum_ab;
	logic [7:0] pred;
	logic [7:0] val;
	logic [1:0] status;
	logic       take;

	assign advance = !out_valid || out_ready;
	assign take    = advance && item_valid_s1;
	assign tap     = psu_pkg::bpp_tap(bpp);
	assign a       = left_q[tap];
	assign c       = upleft_q[tap];
	assign b       = item_s1.use_b ? above_byte : 8'd0;
	assign sum_ab  = {1'b0, a} + {1'b0, b};

	always_comb begin
		case (item_s1.kind)
			psu_pkg::FILT_SUB:   pred = a;
			psu_pkg::FILT_UP:    pred = b;
			psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
			psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
			default:             pred = 8'd0;
		endcase
		if (item_s1.bad) begin
			pred = 8'd0;
		end
		val = item_s1.data + pred;
		if (!item_s1.in_store) begin
			status = psu_pkg::STAT_OVERLONG;
		end else if (item_s1.bad) begin
			status = psu_pkg::STAT_BAD_FILT;
		end else begin
			status = psu_pkg::STAT_OK;
		end
	end

	assign wr_en   = take && !item_s1.is_filter && item_s1.in_store;
	assign wr_addr = item_s1.addr;
	assign wr_data = val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else begin
			if (advance) begin
				out_valid <= item_valid_s1 && !item_s1.is_filter;
			end
			if (take) begin
				if (item_s1.is_filter) begin
					for (int i = 0; i < 8; i++) begin
						left_q[i]   <= 8'd0;
						upleft_q[i] <= 8'd0;
					end
				end else begin
					for (int i = 7; i > 0; i--) begin
						left_q[i]   <= left_q[i-1];
						upleft_q[i] <= upleft_q[i-1];
					end
					left_q[0]   <= val;
					upleft_q[0] <= b;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !item_s1.is_filter) begin
			pixel_q  <= val;
			last_q   <= item_s1.last;
			status_q <= status;
		end
	end

endmodule

@@ rtl/png_scanline_unfilter_core.sv @@
// Top level of the PNG scanline unfilter block (filter types none, sub, up, average, Paeth).
//
// The block takes inflated PNG scanline bytes one per transfer and returns the
// reconstructed bytes at one per clock cycle while the output side is ready,
// each passing through the input register and then the output register.
// The first byte of every line is the filter type and yields no output;
// tuser on that byte set to one makes the line above read as zeros (image
// start or a new interlace pass), and tlast on it gives an empty line. Every
// later byte yields one output with tlast copied through and a status: ok,
// unknown filter type (the byte then passes unchanged), or line longer than
// the 8192-byte line store (the above byte then reads as zero and the
// byte is not stored; this status wins). The line store is a RAM whose read
// is issued at the input transfer, so the above byte arrives together with
// the input register; the previous reconstructed bytes come from an
// eight-deep history, so the left-neighbor dependence is one short adder and
// predictor path per cycle. Each line must be no longer than the line above
// it within a pass, since bytes above the end of the previous line are not
// defined. bytes_per_pixel (cfg_wdata, reset 1, 0 acts as 1 and values
// above 8 act as 8) may only be written while the block is idle. While a
// result waits at the output, a transfer needs an empty input register.
module png_scanline_unfilter_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [psu_pkg::BPP_W-1:0] cfg_wdata,     // bytes_per_pixel
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // [7:0] data_byte
	input  logic                      s_axis_tlast,  // line_end
	input  logic                      s_axis_tuser,  // pass_start
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // [7:0] pixel_byte, [9:8] status
	output logic                      m_axis_tlast   // last_of_line
);

	logic [psu_pkg::BPP_W-1:0]  bpp_q;
	logic                       advance;
	logic                       item_valid_s1;
	psu_pkg::psu_item_t         item_s1;
	logic                       rd_en;
	logic [psu_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]                 rd_data;
	logic                       wr_en;
	logic [psu_pkg::ADDR_W-1:0] wr_addr;
	logic [7:0]                 wr_data;
	logic [7:0]                 pixel;
	logic [1:0]                 status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= psu_pkg::BPP_W'(1);
		end else if (cfg_we) begin
			bpp_q <= cfg_wdata;
		end
	end

	// Framing state and the input register.
	psu_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_data       (s_axis_tdata),
		.in_last       (s_axis_tlast),
		.in_pass_start (s_axis_tuser),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr)
	);

	// Previous reconstructed line. Contents are undefined until a line is written.
	psu_ram #(
		.WIDTH (8),
		.DEPTH (psu_pkg::MAX_LINE_BYTES)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Prediction, history update and the output register.
	psu_recon u_recon (
		.clk           (clk),
		.arst_n        (arst_n),
		.bpp           (bpp_q),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.above_byte    (rd_data),
		.advance       (advance),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.pixel_q       (pixel),
		.last_q        (m_axis_tlast),
		.status_q      (status)
	);

	assign m_axis_tdata = {6'b0, status, pixel};

endmodule

@@ rtl/psu_checker.sv @@
// Port-level assertions for the PNG scanline unfilter top level, bound to it.
module psu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output transfer changed");

	// The padding bits above the status field stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
		else $error("output padding bits not zero");

	// Status never carries the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[9:8] != 2'b11)
		else $error("output status code out of range");

	// No result appears without a preceding input transfer.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_xfer) && !in_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("output transfer without a preceding input transfer");

endmodule

bind png_scanline_unfilter_core psu_checker u_psu_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the PNG scanline unfilter core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// One byte of the inflated scanline stream as it goes over the slave side.
	typedef struct {
		logic [7:0] data;
		logic       line_end;
		logic       pass_start;
	} scan_byte_t;

	// One reconstructed byte as it should leave the master side.
	typedef struct {
		logic [7:0] pixel;
		logic       last;
		logic [1:0] status;
	} pixel_t;

	typedef logic [7:0] byte_q_t [$];

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [psu_pkg::BPP_W-1:0]     cfg_wdata = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata = '0;   // [7:0] data_byte
	logic                          s_axis_tlast = 1'b0; // line_end
	logic                          s_axis_tuser = 1'b0; // pass_start
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [15:0]                   m_axis_tdata;        // [7:0] pixel_byte, [9:8] status
	logic                          m_axis_tlast;        // last_of_line

	png_scanline_unfilter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// Bytes waiting to be sent, the byte now on the bus, and the pixels still owed.
	scan_byte_t pending_bytes [$];
	scan_byte_t staged_bytes [$];
	scan_byte_t on_bus;
	pixel_t     expected_pixels [$];

	int unsigned gap_pct = 0;   // chance per cycle that the sender holds back
	int unsigned stall_pct = 0; // chance per cycle that the receiver is not ready
	int unsigned mismatches = 0;

	// Predictor state: our own copy of the line store, histories and filter state.
	logic [psu_pkg::BPP_W-1:0] bpp_cfg = psu_pkg::BPP_W'(1);
	logic [7:0]                above_line [psu_pkg::MAX_LINE_BYTES];
	logic                      above_ok = 1'b0;
	logic [7:0]                left_hist [8];
	logic [7:0]                upleft_hist [8];
	logic [2:0]                kind = psu_pkg::FILT_NONE;
	logic                      bad_kind = 1'b0;
	logic                      want_filter = 1'b1;
	int                        pos = 0;

	// Generator bookkeeping: a line may not outgrow the stored line above it.
	bit gen_above_ok = 1'b0;
	int gen_above_len = 0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		end
	endtask

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		int est;
		int da;
		int db;
		int dc;
		est = int'(a) + int'(b) - int'(c);
		da = est - int'(a);
		db = est - int'(b);
		dc = est - int'(c);
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) return a;
		if (db <= dc) return b;
		return c;
	endfunction

	// Applies one accepted byte to the predictor and queues the pixel it yields, if any.
	task automatic reconstruct(input scan_byte_t sb);
		pixel_t     px;
		int         left_dist;
		logic       fits;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] pred;
		if (want_filter) begin
			if (sb.pass_start) above_ok = 1'b0;
			bad_kind = (sb.data > 8'(psu_pkg::FILT_PAETH));
			kind = bad_kind ? psu_pkg::FILT_NONE : sb.data[2:0];
			for (int k = 0; k < 8; k++) begin
				left_hist[k] = '0;
				upleft_hist[k] = '0;
			end
			pos = 0;
			want_filter = sb.line_end;
			return;
		end
		left_dist = (bpp_cfg == 0) ? 1 : (bpp_cfg > 8) ? 8 : int'(bpp_cfg);
		fits = (pos < psu_pkg::MAX_LINE_BYTES);
		a = left_hist[left_dist-1];
		c = upleft_hist[left_dist-1];
		b = (fits && above_ok) ? above_line[pos] : 8'h00;
		case (kind)
			psu_pkg::FILT_SUB:   pred = a;
			psu_pkg::FILT_UP:    pred = b;
			psu_pkg::FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
			psu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
			default:             pred = 8'h00;
		endcase
		if (bad_kind) pred = 8'h00;
		px.pixel = sb.data + pred;
		px.last = sb.line_end;
		px.status = !fits ? psu_pkg::STAT_OVERLONG :
			bad_kind ? psu_pkg::STAT_BAD_FILT : psu_pkg::STAT_OK;
		for (int k = 7; k > 0; k--) begin
			left_hist[k] = left_hist[k-1];
			upleft_hist[k] = upleft_hist[k-1];
		end
		left_hist[0] = px.pixel;
		upleft_hist[0] = b;
		if (fits) begin
			above_line[pos] = px.pixel;
			pos++;
		end
		if (sb.line_end) begin
			want_filter = 1'b1;
			above_ok = 1'b1;
			pos = 0;
		end
		expected_pixels.push_back(px);
	endtask

	// Driver: feeds the slave side from the pending queue and predicts every transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				reconstruct(on_bus);
			end
			// The bus is free once nothing is offered or the offer was just taken.
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
					on_bus = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= on_bus.data;
					s_axis_tlast <= on_bus.line_end;
					s_axis_tuser <= on_bus.pass_start;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure on the master side and a field-by-field check.
	always @(posedge clk) begin
		pixel_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected output transfer", m_axis_tdata, 16'h0000);
				end else begin
					want = expected_pixels.pop_front();
					if (m_axis_tdata[7:0] !== want.pixel)
						report_mismatch("pixel_byte", 16'(m_axis_tdata[7:0]), 16'(want.pixel));
					if (m_axis_tlast !== want.last)
						report_mismatch("last_of_line", 16'(m_axis_tlast), 16'(want.last));
					if (m_axis_tdata[9:8] !== want.status)
						report_mismatch("status", 16'(m_axis_tdata[9:8]), 16'(want.status));
				end
			end
		end
	end

	// Stages a filter byte and its line; tuser on data bytes is ignored, so it is random.
	task automatic put_line(input logic [7:0] ftype, input bit pstart, input byte_q_t body);
		scan_byte_t sb;
		sb.data = ftype;
		sb.line_end = (body.size() == 0);
		sb.pass_start = pstart;
		staged_bytes.push_back(sb);
		foreach (body[i]) begin
			sb.data = body[i];
			sb.line_end = (i == body.size() - 1);
			sb.pass_start = 1'($urandom_range(1));
			staged_bytes.push_back(sb);
		end
		if (pstart) gen_above_ok = 1'b0;
		if (body.size() != 0) begin
			gen_above_ok = 1'b1;
			gen_above_len = (body.size() < psu_pkg::MAX_LINE_BYTES) ? body.size() :
				psu_pkg::MAX_LINE_BYTES;
		end
	endtask

	task automatic random_line(input int len_override);
		byte_q_t    body;
		int         n;
		int         r;
		bit         pstart;
		logic [7:0] ftype;
		r = $urandom_range(99);
		if (len_override > 0) n = len_override;
		else if (r < 6) n = 0;
		else if (r < 60 && gen_above_ok && gen_above_len <= 64) n = gen_above_len;
		else n = $urandom_range(1, 48);
		pstart = ($urandom_range(99) < 12);
		if (gen_above_ok && !pstart && n > gen_above_len) begin
			if (len_override > 0 || $urandom_range(1)) pstart = 1'b1;
			else n = gen_above_len;
		end
		ftype = ($urandom_range(99) < 85) ? 8'($urandom_range(4)) : 8'($urandom_range(5, 255));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			body.push_back(r < 10 ? 8'h00 : r < 20 ? 8'hFF : 8'($urandom_range(255)));
		end
		put_line(ftype, pstart, body);
	endtask

	// Returns at a falling edge once nothing is queued, offered or owed.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_bytes.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_bpp(input logic [psu_pkg::BPP_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bpp_cfg = value;
		@(negedge clk);
	endtask

	initial begin
		logic [psu_pkg::BPP_W-1:0] bpp_plan [11] = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd2, 4'd5,
			4'd9, 4'd4, 4'd1, 4'd7, 4'd6};
		byte_q_t body;
		int      split;
		for (int k = 0; k < 8; k++) begin
			left_hist[k] = '0;
			upleft_hist[k] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 12; ph++) begin
			// Registers change only with the block idle; filter bytes yield no pixel,
			// so the drain check misses them and the bench waits longer before the write.
			if (ph > 0) begin
				repeat (4) @(negedge clk);
				write_bpp(bpp_plan[ph-1]);
			end
			gap_pct = (ph < 4) ? 21 : (ph < 8) ? 57 : 0;
			stall_pct = (ph < 4) ? 57 : (ph < 8) ? 21 : 0;

			if (ph == 0) begin
				// Every filter type on extreme bytes, an empty line carrying pass start,
				// unknown filter types at both ends of their range.
				body = {};
				put_line(8'(psu_pkg::FILT_NONE), 1'b1, body);
				body = '{8'h00, 8'hFF, 8'h5A};
				put_line(8'(psu_pkg::FILT_NONE), 1'b0, body);
				body = '{8'hFF, 8'h01, 8'h80};
				put_line(8'(psu_pkg::FILT_SUB), 1'b0, body);
				body = '{8'h01, 8'hFF, 8'h00};
				put_line(8'(psu_pkg::FILT_UP), 1'b0, body);
				body = '{8'hFF, 8'hFF, 8'h01};
				put_line(8'(psu_pkg::FILT_AVG), 1'b0, body);
				body = '{8'h00, 8'h80, 8'hFF};
				put_line(8'(psu_pkg::FILT_PAETH), 1'b0, body);
				body = '{8'h00, 8'hFF};
				put_line(8'd5, 1'b0, body);
				body = '{8'h7F};
				put_line(8'hFF, 1'b1, body);
			end
			while (staged_bytes.size() < 120) random_line(0);

			// Feed the phase in two parts, pausing the sender in between (often in
			// mid-line) until every pixel owed so far has arrived.
			split = $urandom_range(1, staged_bytes.size() - 1);
			for (int i = 0; i < split; i++) pending_bytes.push_back(staged_bytes.pop_front());
			wait_drained();
			while (staged_bytes.size() != 0) pending_bytes.push_back(staged_bytes.pop_front());
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
